// ===== hdl/bitmap_first_fit_allocator_unit_defines.svh =====
// Assertion macros for the bitmap first-fit allocator.
`ifndef BITMAP_FIRST_FIT_ALLOCATOR_UNIT_DEFINES_SVH
`define BITMAP_FIRST_FIT_ALLOCATOR_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked while out of reset.
`define BFFA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define BFFA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BFFA_ASSERT(lbl, clk, rst_n, prop, msg)
`define BFFA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== hdl/bffa_pkg.sv =====
// Shared types, codes and helpers for the bitmap first-fit allocator.
package bffa_pkg;

    // Field widths
    localparam int UNIT_BYTES_W = 16;
    localparam int TOTAL_W      = 11;
    localparam int REQ_W        = 24;
    localparam int START_W      = 10;
    localparam int CNT_W        = 11;
    localparam int STATUS_W     = 2;

    // Config port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_UNIT_BYTES  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_UNITS = 1'b1;
    localparam logic [UNIT_BYTES_W-1:0] UNIT_BYTES_RST = 16'd1;
    localparam logic [TOTAL_W-1:0]      TOTAL_RST      = 11'd1024;

    // Operation and status codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD     = 2'd2;

    // Map geometry
    localparam int DEF_MAX_UNITS = 1024;
    localparam int LIM_MAX       = 2 ** TOTAL_W - 1;
    localparam int WORD_W        = 32;
    localparam int WORD_LW       = 5;

    // Divider geometry: rounded-up dividend is req + ub - 1
    localparam int DIV_DW = REQ_W + 1;

    // Result of checking one map word
    typedef struct packed {
        logic               hit_cross;  // run carried in from earlier words completes here
        logic               hit_in;     // run lies wholly inside this word
        logic [WORD_LW-1:0] hit_off;    // start bit of the in-word run
        logic               all_free;
        logic [WORD_LW:0]   top_free;   // free bits at the top end of the word
    } scan_res_t;

    // Mask with the lowest n bits set, n in 0..WORD_W
    function automatic logic [WORD_W-1:0] low_ones(input logic [WORD_LW:0] n);
        logic [WORD_W-1:0] r;
        if (n >= (WORD_LW + 1)'(WORD_W))
            r = '1;
        else
            r = (WORD_W'(1) << n) - WORD_W'(1);
        return r;
    endfunction

endpackage

// ===== hdl/bffa_div.sv =====
// Restoring divider, one quotient bit per cycle.
module bffa_div #(
    parameter int DW = 25,
    parameter int VW = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);
    localparam int CNTW = $clog2(DW + 1);

    logic            run_reg, run_next;
    logic            done_reg, done_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [VW-1:0]   rem_reg, rem_next;
    logic [DW-1:0]   quo_reg, quo_next;
    logic [VW-1:0]   dvs_reg, dvs_next;
    logic [VW:0]     shifted;
    logic [VW:0]     diff;
    logic            ge;

    // One shift-subtract step
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[DW-1]};
        diff      = shifted - {1'b0, dvs_reg};
        ge        = shifted >= {1'b0, dvs_reg};
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            rem_next = '0;
            quo_next = dividend;
            dvs_next = divisor;
        end
        else if (run_reg)
        begin
            rem_next = ge ? diff[VW-1:0] : shifted[VW-1:0];
            quo_next = {quo_reg[DW-2:0], ge};
            cnt_next = cnt_reg + CNTW'(1);
            if (cnt_reg == CNTW'(DW - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== hdl/bffa_scan.sv =====
// Checks one 32-bit map word for a free run of the needed length.
module bffa_scan (
    input  logic [bffa_pkg::WORD_W-1:0]  word,
    input  logic [bffa_pkg::WORD_LW:0]   avail,
    input  logic [bffa_pkg::TOTAL_W-1:0] need,
    input  logic [bffa_pkg::TOTAL_W-1:0] run_in,
    output bffa_pkg::scan_res_t          res
);
    import bffa_pkg::*;

    logic [WORD_W-1:0] used_m;
    logic [WORD_W-1:0] pw [0:WORD_LW];
    logic [WORD_W-1:0] acc;
    logic              started;
    logic              fits_word;
    logic [WORD_W-1:0] starts;
    logic [WORD_LW:0]  tz;
    logic [WORD_LW:0]  lz;
    logic [WORD_LW-1:0] off;

    always_comb
    begin
        // Units past the usable limit count as used
        used_m = word | ~low_ones(avail);

        // pw[k][i]: 2**k free bits starting at bit i
        pw[0] = ~used_m;
        for (int k = 0; k < WORD_LW; k++)
            pw[k+1] = pw[k] & (pw[k] >> (1 << k));

        // Chain windows by the binary digits of need
        acc     = '1;
        started = 1'b0;
        for (int k = 0; k <= WORD_LW; k++)
        begin
            if (need[k])
            begin
                acc     = started ? (pw[k] & (acc >> (1 << k))) : pw[k];
                started = 1'b1;
            end
        end
        fits_word = (need[TOTAL_W-1:WORD_LW+1] == '0) && (need != '0);
        starts    = fits_word ? acc : '0;

        // Lowest run start
        off = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
            if (starts[i])
                off = WORD_LW'(i);

        // Free bits at the low end
        tz = (WORD_LW + 1)'(WORD_W);
        for (int i = WORD_W - 1; i >= 0; i--)
            if (used_m[i])
                tz = (WORD_LW + 1)'(i);

        // Free bits at the high end
        lz = (WORD_LW + 1)'(WORD_W);
        for (int i = 0; i < WORD_W; i++)
            if (used_m[i])
                lz = (WORD_LW + 1)'(WORD_W - 1 - i);

        res.hit_cross = (run_in != '0) &&
                        (((TOTAL_W + 1)'(run_in) + (TOTAL_W + 1)'(tz)) >=
                         (TOTAL_W + 1)'(need));
        res.hit_in    = starts != '0;
        res.hit_off   = off;
        res.all_free  = used_m == '0;
        res.top_free  = lz;
    end

endmodule

// ===== hdl/bffa_map.sv =====
// Usage bitmap storage: one word per row, row valid bits give the cleared state.
module bffa_map #(
    parameter int WORDS = 32,
    parameter int WA    = 5
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rd_en,
    input  logic [WA-1:0]               rd_addr,
    output logic [bffa_pkg::WORD_W-1:0] rd_data,
    input  logic                        wr_en,
    input  logic [WA-1:0]               wr_addr,
    input  logic [bffa_pkg::WORD_W-1:0] wr_data
);
    import bffa_pkg::*;

    logic [WORD_W-1:0] mem_reg [0:WORDS-1];
    logic [WORDS-1:0]  valid_reg;
    logic              rd_valid_reg;
    logic [WORD_W-1:0] rd_word_reg;

    // Row valid bits: a row never written reads as all free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
                valid_reg[wr_addr] <= 1'b1;
            if (rd_en)
                rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    // Storage with registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_addr] <= wr_data;
        if (rd_en)
            rd_word_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_valid_reg ? rd_word_reg : '0;

endmodule

// ===== hdl/bitmap_first_fit_allocator_unit.sv =====
// Bitmap first-fit allocator top level: sequencer, config registers, result registers.
//
// Channels: start/busy command input; an item is taken at an edge with start high and busy
// low. op 0 allocates request_bytes rounded up to whole units; op 1 frees free_units units
// from start_unit. Each item gives exactly one result beat, shown for one cycle with done
// high: status, granted_start, granted_units. The receiver cannot stall; busy stays high
// from the accept until the cycle of done, and the next item may be taken in that cycle.
// Config: cfg_write with cfg_index selects unit_bytes (0) or total_units (1); write only
// while idle.
// Sequence: a free rewrites each map word of its range (at most 32 words with 1024 units);
// a bad request touches no map word. An allocate first runs the bit-serial divide for the
// round-up, then reads and checks one 32-bit map word at a time from unit 0 (one shared
// word checker, one memory read port), then rewrites each word of the granted run.
// Reset: map reads as all free at once (row valid bits), unit_bytes 1, total_units 1024.
`include "bitmap_first_fit_allocator_unit_defines.svh"

module bitmap_first_fit_allocator_unit #(
    parameter int MAX_UNITS = bffa_pkg::DEF_MAX_UNITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [bffa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bffa_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            start,
    output logic                            busy,
    input  logic                            op,
    input  logic [bffa_pkg::REQ_W-1:0]      request_bytes,
    input  logic [bffa_pkg::START_W-1:0]    start_unit,
    input  logic [bffa_pkg::CNT_W-1:0]      free_units,
    output logic                            done,
    output logic [bffa_pkg::STATUS_W-1:0]   status,
    output logic [bffa_pkg::START_W-1:0]    granted_start,
    output logic [bffa_pkg::CNT_W-1:0]      granted_units
);
    import bffa_pkg::*;

    // Geometry; units past LIM_MAX can never be usable
    localparam int STORE_UNITS = (MAX_UNITS < LIM_MAX + 1) ? MAX_UNITS : LIM_MAX + 1;
    localparam int WORDS       = (STORE_UNITS + WORD_W - 1) / WORD_W;
    localparam int WA          = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int WC          = WA + 1;
    localparam int CW          = (WC + WORD_LW > TOTAL_W + 1) ? WC + WORD_LW : TOTAL_W + 1;
    localparam int LIM_CAP     = (MAX_UNITS < LIM_MAX) ? MAX_UNITS : LIM_MAX;

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CHK  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_SRD  = 3'd3;
    localparam logic [2:0] S_SEV  = 3'd4;
    localparam logic [2:0] S_MRD  = 3'd5;
    localparam logic [2:0] S_MWR  = 3'd6;

    logic [2:0]              state_reg, state_next;
    logic [UNIT_BYTES_W-1:0] unit_bytes_reg;
    logic [TOTAL_W-1:0]      total_units_reg;
    logic                    op_reg;
    logic [REQ_W-1:0]        req_reg;
    logic [START_W-1:0]      start_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [TOTAL_W-1:0]      need_reg, need_next;
    logic [WC-1:0]           w_reg, w_next;
    logic [TOTAL_W-1:0]      run_reg, run_next;
    logic [TOTAL_W-1:0]      run_start_reg, run_start_next;
    logic [TOTAL_W-1:0]      lo_reg, lo_next;
    logic [TOTAL_W-1:0]      hi_reg, hi_next;
    logic                    set_reg, set_next;
    logic                    done_reg, done_next;
    logic [STATUS_W-1:0]     status_reg, status_next;
    logic [START_W-1:0]      gstart_reg, gstart_next;
    logic [CNT_W-1:0]        gunits_reg, gunits_next;

    logic [TOTAL_W-1:0]      lim;
    logic [UNIT_BYTES_W-1:0] ub_eff;
    logic [CW-1:0]           base_c;
    logic [CW-1:0]           lim_c;
    logic [CW-1:0]           lim_diff;
    logic [WORD_LW:0]        avail;
    logic [TOTAL_W-1:0]      base_u;
    logic [TOTAL_W:0]        free_end;
    logic [TOTAL_W-1:0]      found_start;
    logic [CW-1:0]           lo_d;
    logic [CW-1:0]           hi_d;
    logic [WORD_LW:0]        lo_off;
    logic [WORD_LW:0]        hi_off;
    logic [WORD_W-1:0]       range_mask;

    logic                    div_start;
    logic [DIV_DW-1:0]       div_dividend;
    logic                    div_done;
    logic [DIV_DW-1:0]       div_quo;

    logic                    rd_en;
    logic [WORD_W-1:0]       rd_data;
    logic                    wr_en;
    logic [WORD_W-1:0]       wr_data;
    scan_res_t               scan_res;

    logic                    ok_beat;
    logic                    grant_zero;

    // Usable total and unit size
    assign lim    = (total_units_reg > TOTAL_W'(LIM_CAP)) ? TOTAL_W'(LIM_CAP) : total_units_reg;
    assign ub_eff = (unit_bytes_reg == '0) ? UNIT_BYTES_W'(1) : unit_bytes_reg;

    // Current word position
    assign base_c   = CW'({w_reg, {WORD_LW{1'b0}}});
    assign base_u   = base_c[TOTAL_W-1:0];
    assign lim_c    = CW'(lim);
    assign lim_diff = lim_c - base_c;
    assign avail    = (lim_diff >= CW'(WORD_W)) ? (WORD_LW + 1)'(WORD_W) : lim_diff[WORD_LW:0];

    // Bits of [lo, hi) that fall into the current word
    always_comb
    begin
        lo_d       = CW'(lo_reg) - base_c;
        hi_d       = CW'(hi_reg) - base_c;
        lo_off     = (CW'(lo_reg) <= base_c) ? '0 : lo_d[WORD_LW:0];
        hi_off     = (hi_d >= CW'(WORD_W)) ? (WORD_LW + 1)'(WORD_W) : hi_d[WORD_LW:0];
        range_mask = low_ones(hi_off) & ~low_ones(lo_off);
    end

    assign free_end     = (TOTAL_W + 1)'(start_reg) + (TOTAL_W + 1)'(cnt_reg);
    assign found_start  = scan_res.hit_cross ? run_start_reg
                                             : base_u + TOTAL_W'(scan_res.hit_off);
    assign div_dividend = DIV_DW'(req_reg) + DIV_DW'(ub_eff) - DIV_DW'(1);
    assign wr_data      = set_reg ? (rd_data | range_mask) : (rd_data & ~range_mask);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        need_next      = need_reg;
        w_next         = w_reg;
        run_next       = run_reg;
        run_start_next = run_start_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        set_next       = set_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        gstart_next    = gstart_reg;
        gunits_next    = gunits_reg;
        div_start      = 1'b0;
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                    state_next = S_CHK;
            end
            S_CHK:
            begin
                if (op_reg == OP_ALLOC)
                begin
                    if (req_reg == '0)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_BAD;
                        gstart_next = '0;
                        gunits_next = '0;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                end
                else if ((cnt_reg == '0) || (free_end > (TOTAL_W + 1)'(lim)))
                begin
                    done_next   = 1'b1;
                    status_next = ST_BAD;
                    gstart_next = '0;
                    gunits_next = '0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    lo_next    = TOTAL_W'(start_reg);
                    hi_next    = free_end[TOTAL_W-1:0];
                    w_next     = WC'(start_reg >> WORD_LW);
                    set_next   = 1'b0;
                    state_next = S_MRD;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    if (div_quo > DIV_DW'(lim))
                    begin
                        done_next   = 1'b1;
                        status_next = ST_NOSPACE;
                        gstart_next = '0;
                        gunits_next = '0;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        need_next      = div_quo[TOTAL_W-1:0];
                        w_next         = '0;
                        run_next       = '0;
                        run_start_next = '0;
                        state_next     = S_SRD;
                    end
                end
            end
            S_SRD:
            begin
                // Past the usable limit: no fitting run
                if (base_c >= lim_c)
                begin
                    done_next   = 1'b1;
                    status_next = ST_NOSPACE;
                    gstart_next = '0;
                    gunits_next = '0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = S_SEV;
                end
            end
            S_SEV:
            begin
                if (scan_res.hit_cross || scan_res.hit_in)
                begin
                    lo_next    = found_start;
                    hi_next    = found_start + need_reg;
                    w_next     = WC'(found_start >> WORD_LW);
                    set_next   = 1'b1;
                    state_next = S_MRD;
                end
                else
                begin
                    // Carry the free run at the top of the word into the next one
                    if (scan_res.all_free)
                    begin
                        if (run_reg == '0)
                            run_start_next = base_u;
                        run_next = run_reg + TOTAL_W'(WORD_W);
                    end
                    else
                    begin
                        run_next       = TOTAL_W'(scan_res.top_free);
                        run_start_next = base_u + TOTAL_W'(WORD_W) - TOTAL_W'(scan_res.top_free);
                    end
                    w_next     = w_reg + WC'(1);
                    state_next = S_SRD;
                end
            end
            S_MRD:
            begin
                rd_en      = 1'b1;
                state_next = S_MWR;
            end
            S_MWR:
            begin
                wr_en = 1'b1;
                if (CW'(hi_reg) > base_c + CW'(WORD_W))
                begin
                    w_next     = w_reg + WC'(1);
                    state_next = S_MRD;
                end
                else
                begin
                    done_next   = 1'b1;
                    status_next = ST_OK;
                    gstart_next = lo_reg[START_W-1:0];
                    gunits_next = CNT_W'(hi_reg - lo_reg);
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state and config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            done_reg        <= 1'b0;
            unit_bytes_reg  <= UNIT_BYTES_RST;
            total_units_reg <= TOTAL_RST;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_UNIT_BYTES:  unit_bytes_reg  <= cfg_data;
                    CFG_TOTAL_UNITS: total_units_reg <= cfg_data[TOTAL_W-1:0];
                    default:         ;
                endcase
            end
        end
    end

    // Item and working registers
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && start)
        begin
            op_reg    <= op;
            req_reg   <= request_bytes;
            start_reg <= start_unit;
            cnt_reg   <= free_units;
        end
        need_reg      <= need_next;
        w_reg         <= w_next;
        run_reg       <= run_next;
        run_start_reg <= run_start_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        set_reg       <= set_next;
        status_reg    <= status_next;
        gstart_reg    <= gstart_next;
        gunits_reg    <= gunits_next;
    end

    // Round-up divider
    bffa_div #(
        .DW(DIV_DW),
        .VW(UNIT_BYTES_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (ub_eff),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Usage bitmap
    bffa_map #(
        .WORDS(WORDS),
        .WA   (WA)
    ) u_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (w_reg[WA-1:0]),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (w_reg[WA-1:0]),
        .wr_data (wr_data)
    );

    // Shared word checker
    bffa_scan u_scan (
        .word   (rd_data),
        .avail  (avail),
        .need   (need_reg),
        .run_in (run_reg),
        .res    (scan_res)
    );

    assign busy          = state_reg != S_IDLE;
    assign done          = done_reg;
    assign status        = status_reg;
    assign granted_start = gstart_reg;
    assign granted_units = gunits_reg;

    // Result beat classes for the checks
    assign ok_beat    = done && (status == ST_OK);
    assign grant_zero = (granted_start == '0) && (granted_units == '0);

    // Checks
    `BFFA_ASSERT_ALWAYS(a_done_idle, clk, done |-> !busy, "result beat while busy")
    `BFFA_ASSERT(a_done_after_work, clk, rst_n, done |-> $past(busy), "result beat without work")
    `BFFA_ASSERT(a_fail_zero, clk, rst_n, (done && !ok_beat) |-> grant_zero, "failed beat with a grant")
    `BFFA_ASSERT(a_ok_units, clk, rst_n, ok_beat |-> (granted_units != '0), "ok beat with no units")

endmodule
